// ===== hdl/btcc_pkg.sv =====
// shared types and constants of the buzzer tone command controller
`default_nettype none

package btcc_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned BtnW  = 3;

  localparam logic [DataW-1:0] PeriodReset   = 16'd7575;
  localparam logic [DataW-1:0] OctaveBase    = 16'd127;
  localparam logic [DataW-1:0] TickMax       = 16'hFFFF;
  localparam logic [DataW-1:0] DurationReset = 16'd2000;
  localparam logic [2:0]       PosIdle       = 3'd4;
  localparam logic [BtnW-1:0]  BtnReleased   = 3'b111;

  // serial command characters
  localparam logic [7:0] ChPlay = 8'h70;  // 'p'
  localparam logic [7:0] ChStop = 8'h73;  // 's'
  localparam logic [7:0] ChDown = 8'h2C;  // ','
  localparam logic [7:0] ChUp   = 8'h2E;  // '.'
  localparam logic [7:0] ChDur  = 8'h64;  // 'd'
  localparam logic [7:0] ChDig0 = 8'h30;  // '0'
  localparam logic [7:0] ChDig9 = 8'h39;  // '9'
  localparam logic [7:0] ChHexA = 8'h61;  // 'a'
  localparam logic [7:0] ChHexF = 8'h66;  // 'f'

  // button bit positions
  localparam int unsigned BtnPlay = 0;
  localparam int unsigned BtnDown = 1;
  localparam int unsigned BtnUp   = 2;

  typedef enum logic [1:0] {
    CMD_SERIAL = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_BUTTON = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [7:0]      rx_byte;
    logic [BtnW-1:0] buttons;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] tone_period;
    logic [DataW-1:0] compare_value;
    logic             playing;
    logic [DataW-1:0] duration_limit;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/btcc_octave.sv =====
// period shifter: base period scaled by the octave offset
`default_nettype none

module btcc_octave
  import btcc_pkg::*;
(
  input  wire logic [DataW-1:0] base_period_i,
  input  wire logic [DataW-1:0] octave_i,
  output logic      [DataW-1:0] period_o
);

  logic [DataW-1:0] sh_up;
  logic [DataW-1:0] sh_dn;

  always_comb begin
    sh_up = octave_i - OctaveBase;
    sh_dn = OctaveBase - octave_i;
    if (octave_i > OctaveBase) begin
      // higher octave, shorter period
      if (sh_up >= DataW'(16)) begin
        period_o = '0;
      end else begin
        period_o = base_period_i >> sh_up[3:0];
      end
    end else if (octave_i < OctaveBase) begin
      if (sh_dn >= DataW'(16)) begin
        period_o = '0;
      end else begin
        period_o = base_period_i << sh_dn[3:0];
      end
    end else begin
      period_o = base_period_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/btcc_core.sv =====
// controller state and its per-word update
`default_nettype none

module btcc_core
  import btcc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire item_t            item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [DataW-1:0] cfg_wdata_i,
  output result_t               result_o
);

  logic [DataW-1:0] base_q, octave_q, octave_d, period_q, period_d;
  logic [DataW-1:0] dur_q, dur_d, tick_q, tick_d, entry_q, entry_d, shifted;
  logic [2:0]       pos_q, pos_d;
  logic [BtnW-1:0]  prev_q, prev_d;
  logic             play_q, play_d, oct_chg;
  logic             idle, is_digit;
  logic [3:0]       digit;
  logic [7:0]       ch;
  logic [BtnW-1:0]  b;

  btcc_octave u_octave (
    .base_period_i (base_q),
    .octave_i      (octave_d),
    .period_o      (shifted)
  );

  always_comb begin
    octave_d = octave_q;
    oct_chg  = 1'b0;
    play_d   = play_q;
    dur_d    = dur_q;
    tick_d   = tick_q;
    entry_d  = entry_q;
    pos_d    = pos_q;
    prev_d   = prev_q;
    ch       = item_i.rx_byte;
    b        = item_i.buttons;
    idle     = pos_q[2];
    is_digit = 1'b0;
    digit    = '0;

    if (ch >= ChDig0 && ch <= ChDig9) begin
      is_digit = 1'b1;
      digit    = 4'(ch - ChDig0);
    end else if (ch >= ChHexA && ch <= ChHexF) begin
      is_digit = 1'b1;
      digit    = 4'(ch - ChHexA + 8'd10);
    end

    if (step_i) begin
      case (item_i.cmd)
        CMD_SERIAL: begin
          if (ch == ChPlay) begin
            tick_d = '0;
            play_d = 1'b1;
          end else if (ch == ChStop) begin
            play_d = 1'b0;
          end else if (ch == ChDown) begin
            octave_d = octave_q - 1'b1;
            oct_chg  = 1'b1;
          end else if (ch == ChUp) begin
            octave_d = octave_q + 1'b1;
            oct_chg  = 1'b1;
          end else if (ch == ChDur && idle) begin
            pos_d   = '0;
            entry_d = '0;
          end else if (!idle && is_digit) begin
            // most significant nibble first
            entry_d = entry_q | ({digit, 12'h000} >> {pos_q[1:0], 2'b00});
            pos_d   = pos_q + 1'b1;
            if (pos_q[1:0] == 2'd3) begin
              dur_d = entry_d;
            end
          end
        end
        CMD_TICK: begin
          if (tick_q != TickMax) begin
            tick_d = tick_q + 1'b1;
          end
        end
        CMD_BUTTON: begin
          if (!b[BtnPlay]) begin
            if (prev_q[BtnPlay]) begin
              tick_d = '0;
            end
            play_d = 1'b1;
          end else if (tick_q >= dur_q) begin
            play_d = 1'b0;
          end
          // down then up edge may both act: net index, one period update
          if (!b[BtnDown] && prev_q[BtnDown]) begin
            oct_chg = 1'b1;
          end
          if (!b[BtnUp] && prev_q[BtnUp]) begin
            oct_chg = 1'b1;
          end
          if ((!b[BtnDown] && prev_q[BtnDown]) && !(!b[BtnUp] && prev_q[BtnUp])) begin
            octave_d = octave_q - 1'b1;
          end else if (!(!b[BtnDown] && prev_q[BtnDown]) && (!b[BtnUp] && prev_q[BtnUp])) begin
            octave_d = octave_q + 1'b1;
          end
          prev_d = b;
        end
        default: begin
        end
      endcase
    end

    period_d = oct_chg ? shifted : period_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= PeriodReset;
      octave_q <= OctaveBase;
      period_q <= PeriodReset;
      play_q   <= 1'b0;
      dur_q    <= DurationReset;
      tick_q   <= TickMax;
      pos_q    <= PosIdle;
      entry_q  <= '0;
      prev_q   <= BtnReleased;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      octave_q <= octave_d;
      period_q <= period_d;
      play_q   <= play_d;
      dur_q    <= dur_d;
      tick_q   <= tick_d;
      pos_q    <= pos_d;
      entry_q  <= entry_d;
      prev_q   <= prev_d;
    end
  end

  always_comb begin
    result_o.tone_period    = period_d;
    result_o.compare_value  = play_d ? (period_d >> 1) : period_d;
    result_o.playing        = play_d;
    result_o.duration_limit = dur_d;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosIdle)
    else $error("digit position out of range");

  a_tick_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.cmd == CMD_TICK && tick_q == TickMax |=> tick_q == TickMax)
    else $error("tick count wrapped");

  a_play_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.cmd == CMD_SERIAL && item_i.rx_byte == ChPlay |=> play_q && tick_q == '0)
    else $error("play command not taken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(period_q) && $stable(play_q) && $stable(dur_q) && $stable(tick_q))
    else $error("state moved without a word");

endmodule

`default_nettype wire

// ===== hdl/buzzer_tone_command_controller.sv =====
// top level of the buzzer tone command controller
// usage:
//   input channel (in_valid_i / in_ready_o) carries one word per event: a
//   received serial character, a timer tick or a sample of the three
//   active-low buttons, selected by cmd_i
//   output channel (out_valid_o / out_ready_i) returns exactly one word per
//   input word with the tone period, compare value, playing flag and the
//   duration limit as they stand after that event
//   cfg_we_i / cfg_wdata_i write the base period; it takes effect at the
//   next octave change
// path: an accepted word goes through the input register, then the state
//   update and the result register
// throughput: one word per cycle unless the result waits; state feedback
//   is a single register stage, so each word sees the state its predecessor left
// reset: asynchronous, active low; both pipeline registers empty, state at
//   its power-up values (base octave, period 7575, duration 2000, stopped)
// stall: while the result word waits, the input register still fills and
//   in_ready_o drops only once it holds a word that cannot move on
`default_nettype none

module buzzer_tone_command_controller
  import btcc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic [BtnW-1:0]  buttons_i,
  input  wire logic             cfg_we_i,
  input  wire logic [DataW-1:0] cfg_wdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [DataW-1:0] tone_period_o,
  output logic      [DataW-1:0] compare_value_o,
  output logic                  playing_o,
  output logic      [DataW-1:0] duration_limit_o
);

  item_t   in_q;
  logic    in_valid_q;
  result_t out_q, res;
  logic    out_valid_q;
  logic    advance, step;

  // result register free or emptying this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  btcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.cmd     <= cmd_e'(cmd_i);
      in_q.rx_byte <= rx_byte_i;
      in_q.buttons <= buttons_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tone_period_o    = out_q.tone_period;
  assign compare_value_o  = out_q.compare_value;
  assign playing_o        = out_q.playing;
  assign duration_limit_o = out_q.duration_limit;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held word lost");

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed word produced no result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_q))
    else $error("waiting result overwritten");

endmodule

`default_nettype wire
